[rtl/core/b32_pkg.sv]
// b32_pkg: shared types, constants and helper functions for the base32 encoder
// no dependencies

package b32_pkg;

    localparam int GROUP_BITS    = 40;
    localparam int GROUP_CHARS   = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [6:0] PAD_CHAR = 7'h3d;

    typedef struct packed {
        logic [GROUP_BITS-1:0] bits;
        logic [3:0]            used;
        logic                  fin;
    } group_t;

    function automatic logic [6:0] char_of(input logic [4:0] v);
        logic [6:0] c;
        if (v < 5'd26)
        begin
            c = 7'(7'h41 + {2'b00, v});
        end
        else
        begin
            c = 7'(7'h32 + {2'b00, v} - 7'd26);
        end
        return c;
    endfunction

    function automatic logic [3:0] data_chars(input logic [2:0] n);
        logic [3:0] u;
        case (n)
            3'd1:    u = 4'd2;
            3'd2:    u = 4'd4;
            3'd3:    u = 4'd5;
            3'd4:    u = 4'd7;
            3'd5:    u = 4'd8;
            default: u = 4'd0;
        endcase
        return u;
    endfunction

endpackage

[rtl/core/b32_front.sv]
// b32_front: accepts raw bytes, holds up to four pending, forms left-aligned groups
// depends on b32_pkg

module b32_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           final_byte,
    input  logic           q_full,
    output logic           q_push,
    output b32_pkg::group_t q_data
);

    logic [31:0] pending_bytes_reg, pending_bytes_next;
    logic [2:0]  pending_count_reg, pending_count_next;
    logic [2:0]  n;
    logic        take;
    logic [39:0] acc;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign n        = pending_count_reg + 3'd1;

    always_comb
    begin
        case (n)
            3'd1:    acc = {data_byte, 32'd0};
            3'd2:    acc = {pending_bytes_reg[7:0], data_byte, 24'd0};
            3'd3:    acc = {pending_bytes_reg[15:0], data_byte, 16'd0};
            3'd4:    acc = {pending_bytes_reg[23:0], data_byte, 8'd0};
            default: acc = {pending_bytes_reg, data_byte};
        endcase
    end

    always_comb
    begin
        q_push             = take && (final_byte || (n == 3'd5));
        q_data.bits        = acc;
        q_data.used        = b32_pkg::data_chars(n);
        q_data.fin         = final_byte;
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (take)
        begin
            if (q_push)
            begin
                pending_bytes_next = 32'd0;
                pending_count_next = 3'd0;
            end
            else
            begin
                pending_bytes_next = {pending_bytes_reg[23:0], data_byte};
                pending_count_next = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 32'd0;
            pending_count_reg <= 3'd0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

[rtl/core/b32_queue.sv]
// b32_queue: short group queue between front and back
// depends on b32_pkg

module b32_queue
#(
    parameter int DEPTH = b32_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b32_pkg::group_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output b32_pkg::group_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    b32_pkg::group_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/b32_back.sv]
// b32_back: serializes one queued group into eight characters, output register
// depends on b32_pkg

module b32_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  b32_pkg::group_t q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [6:0]      out_char,
    output logic            group_last,
    output logic            message_end
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_char_reg;
    logic       group_last_reg;
    logic       message_end_reg;
    logic       load;
    logic       last_char;
    logic [39:0] shifted;
    logic [6:0] ch;

    assign load      = !q_empty && (!out_valid_reg || out_ready);
    assign last_char = (idx_reg == 3'(b32_pkg::GROUP_CHARS - 1));
    assign q_pop     = load && last_char;
    assign shifted   = q_head.bits << (6'd5 * {3'd0, idx_reg});

    always_comb
    begin
        if ({1'b0, idx_reg} < q_head.used)
        begin
            ch = b32_pkg::char_of(shifted[39:35]);
        end
        else
        begin
            ch = b32_pkg::PAD_CHAR;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = 3'(idx_reg + 3'd1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg    <= ch;
            group_last_reg  <= last_char;
            message_end_reg <= last_char && q_head.fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign group_last  = group_last_reg;
    assign message_end = message_end_reg;

endmodule

[rtl/core/base32_encoder.sv]
// base32_encoder: byte-in, character-out base32 encoder (standard alphabet, '=' padding)
// depends on b32_pkg, b32_front, b32_queue, b32_back
// the beat that closes a group writes it into the queue; the back serializer then registers its first character
// throughput: one character per cycle from the back serializer while out_ready is high and the
//   queue is not empty, eight characters per group; bytes are taken while the queue has room
// reset: rst_n clears pending bytes, queue pointers, character index and output valid

module base32_encoder
#(
    parameter int QUEUE_DEPTH = b32_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       group_last,
    output logic       message_end
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    b32_pkg::group_t q_in;
    b32_pkg::group_t q_head;

    b32_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    b32_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    b32_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .group_last  (group_last),
        .message_end (message_end)
    );

endmodule
